// ----- design/line_bresenham_rasterizer_macros.svh -----
// Assertion macros shared by the rasterizer checkers.
// Every macro samples on posedge clk and is disabled while rst_n is low.
`ifndef LINE_BRESENHAM_RASTERIZER_MACROS_SVH
`define LINE_BRESENHAM_RASTERIZER_MACROS_SVH

// Same-cycle implication.
`define LBR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbr assertion failed: same-cycle implication");

// Next-cycle implication.
`define LBR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbr assertion failed: next-cycle implication");

`endif

// ----- design/lbr_pkg.sv -----
// Package for the Bresenham line rasterizer: widths, codes and shared types.
// No dependencies; used by every module of the block.
package lbr_pkg;

  localparam int LBR_COORD_BITS = 14;
  localparam int LBR_REG_W      = 13;
  localparam int LBR_IDX_W      = 24;
  localparam int LBR_COLOR_W    = 32;
  localparam int LBR_CFG_IDX_W  = 1;

  localparam logic [LBR_REG_W-1:0] LBR_SCREEN_RESET = LBR_REG_W'(500);

  typedef enum logic [0:0] {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } lbr_op_t;

  typedef enum logic [LBR_CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } lbr_cfg_idx_t;

  // Status that travels with one pixel from the stepper to the output stage.
  typedef struct packed {
    logic emitted;  // pixel was produced (not an advance while idle)
    logic active;   // more pixels of the line remain
  } lbr_flags_t;

endpackage

// ----- design/line_bresenham_rasterizer.sv -----
// Bresenham line rasterizer, top level: input register, stepper, output stage, config.
// Depends on lbr_pkg, lbr_stepper and lbr_pixel_out.
//
// A start item (tuser 0) loads both endpoints and the color and yields the first
// pixel; each advance item (tuser 1) yields the next pixel along the major axis, or,
// with no line in progress, an idle result with nothing drawn. Exactly one result
// comes out per item, one item per clock sustained while out_tready stays high. An
// item passes the input register, the stepper register and the result register in
// that order, and its result is offered from the result register. Stalls only come
// from out_tready, whose hold-off reaches in_tready in the same cycle.
// The rate is set by the stepper, whose decision term and position loop back through
// their own registers alone; the index multiply sits in the stage after it.
// The user must write screen width and height through the cfg port while the block is idle; nothing enforces it.
module line_bresenham_rasterizer
  import lbr_pkg::*;
#(
  parameter int COORD_BITS = LBR_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // opcode
  input  logic                         in_tuser,
  // x_start, y_start, x_end, y_end, line_color, zero fill
  input  logic [((4*COORD_BITS+LBR_COLOR_W+7)/8)*8-1:0] in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // pixel_valid, line_active
  output logic [1:0]                   out_tuser,
  // pixel_x, pixel_y, pixel_index, pixel_color, zero fill
  output logic [((2*COORD_BITS+LBR_IDX_W+LBR_COLOR_W+7)/8)*8-1:0] out_tdata,
  input  logic                         cfg_wr_en,
  input  logic [LBR_CFG_IDX_W-1:0]     cfg_index,
  input  logic [LBR_REG_W-1:0]         cfg_wdata
);

  localparam int CW   = COORD_BITS;
  localparam int ODW  = ((2*CW+LBR_IDX_W+LBR_COLOR_W+7)/8)*8;

  logic [LBR_REG_W-1:0]    width_r, height_r;
  logic                    in_valid_r;
  logic                    op_r;
  logic signed [CW-1:0]    xs_r, ys_r, xe_r, ye_r;
  logic [LBR_COLOR_W-1:0]  color_r;
  logic                    step_ready;
  logic                    pix_valid, pix_ready;
  lbr_flags_t              pix_flags;
  logic signed [CW-1:0]    pix_x, pix_y;
  logic [LBR_COLOR_W-1:0]  pix_color;
  logic                    o_pv, o_act;
  logic signed [CW-1:0]    o_x, o_y;
  logic [LBR_IDX_W-1:0]    o_index;
  logic [LBR_COLOR_W-1:0]  o_color;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= LBR_SCREEN_RESET;
      height_r <= LBR_SCREEN_RESET;
    end else if (cfg_wr_en) begin
      case (lbr_cfg_idx_t'(cfg_index))
        CFG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
        CFG_SCREEN_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = !in_valid_r || step_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r    <= in_tuser;
      xs_r    <= in_tdata[CW-1:0];
      ys_r    <= in_tdata[2*CW-1:CW];
      xe_r    <= in_tdata[3*CW-1:2*CW];
      ye_r    <= in_tdata[4*CW-1:3*CW];
      color_r <= in_tdata[4*CW+LBR_COLOR_W-1:4*CW];
    end
  end

  lbr_stepper #(.COORD_BITS(COORD_BITS)) u_stepper (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid_r),
    .in_ready   (step_ready),
    .opcode     (op_r),
    .x_start    (xs_r),
    .y_start    (ys_r),
    .x_end      (xe_r),
    .y_end      (ye_r),
    .line_color (color_r),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pix_flags  (pix_flags),
    .pix_x      (pix_x),
    .pix_y      (pix_y),
    .pix_color  (pix_color)
  );

  lbr_pixel_out #(.COORD_BITS(COORD_BITS)) u_pixel_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .screen_width    (width_r),
    .screen_height   (height_r),
    .pix_valid       (pix_valid),
    .pix_ready       (pix_ready),
    .pix_flags       (pix_flags),
    .pix_x           (pix_x),
    .pix_y           (pix_y),
    .pix_color       (pix_color),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_pixel_valid (o_pv),
    .out_line_active (o_act),
    .out_x           (o_x),
    .out_y           (o_y),
    .out_index       (o_index),
    .out_color       (o_color)
  );

  assign out_tuser = {o_act, o_pv};
  assign out_tdata = ODW'({o_color, o_index, o_y, o_x});

endmodule

// ----- design/lbr_stepper.sv -----
// Bresenham stepper: line setup on start items, one major-axis step on advance items in a line.
// Holds the line state and the registered pixel; depends on lbr_pkg.
module lbr_stepper
  import lbr_pkg::*;
#(
  parameter int COORD_BITS = LBR_COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic signed [COORD_BITS-1:0]  x_start,
  input  logic signed [COORD_BITS-1:0]  y_start,
  input  logic signed [COORD_BITS-1:0]  x_end,
  input  logic signed [COORD_BITS-1:0]  y_end,
  input  logic [LBR_COLOR_W-1:0]        line_color,
  output logic                          pix_valid,
  input  logic                          pix_ready,
  output lbr_flags_t                    pix_flags,
  output logic signed [COORD_BITS-1:0]  pix_x,
  output logic signed [COORD_BITS-1:0]  pix_y,
  output logic [LBR_COLOR_W-1:0]        pix_color
);

  localparam int CW = COORD_BITS;
  localparam int DW = COORD_BITS + 3;

  logic signed [CW-1:0]     cur_x_r, cur_x_nxt;
  logic signed [CW-1:0]     cur_y_r, cur_y_nxt;
  logic signed [DW-1:0]     dec_r, dec_nxt;
  logic signed [DW-1:0]     inc_minor_r, inc_minor_nxt;
  logic signed [DW-1:0]     inc_both_r, inc_both_nxt;
  logic [CW-1:0]            left_r, left_nxt;
  logic                     x_neg_r, x_neg_nxt;
  logic                     y_neg_r, y_neg_nxt;
  logic                     major_y_r, major_y_nxt;
  logic [LBR_COLOR_W-1:0]   color_r, color_nxt;
  logic                     emitted;
  logic                     take;
  logic                     pix_valid_r;
  lbr_flags_t               pix_flags_r;
  logic signed [CW-1:0]     pix_x_r, pix_y_r;
  logic [LBR_COLOR_W-1:0]   pix_color_r;

  // Setup and step terms
  logic signed [CW:0]       dx, dy;
  logic [CW-1:0]            adx, ady, major, minor;
  logic                     maj_y;
  logic [DW-1:0]            two_minor, two_major;
  logic                     dec_pos;
  logic signed [CW-1:0]     step_x, step_y;

  assign in_ready = !pix_valid_r || pix_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    dx        = (CW+1)'(x_end) - (CW+1)'(x_start);
    dy        = (CW+1)'(y_end) - (CW+1)'(y_start);
    adx       = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    ady       = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    maj_y     = ady > adx;
    major     = maj_y ? ady : adx;
    minor     = maj_y ? adx : ady;
    two_minor = {2'b00, minor, 1'b0};
    two_major = {2'b00, major, 1'b0};
    dec_pos   = !dec_r[DW-1] && (dec_r != '0);
    step_x    = x_neg_r ? '1 : CW'(1);
    step_y    = y_neg_r ? '1 : CW'(1);
  end

  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    dec_nxt       = dec_r;
    inc_minor_nxt = inc_minor_r;
    inc_both_nxt  = inc_both_r;
    left_nxt      = left_r;
    x_neg_nxt     = x_neg_r;
    y_neg_nxt     = y_neg_r;
    major_y_nxt   = major_y_r;
    color_nxt     = color_r;
    emitted       = 1'b1;
    if (opcode == OP_START) begin
      cur_x_nxt     = x_start;
      cur_y_nxt     = y_start;
      x_neg_nxt     = dx[CW];
      y_neg_nxt     = dy[CW];
      major_y_nxt   = maj_y;
      dec_nxt       = $signed(two_minor - {3'b000, major});
      inc_minor_nxt = $signed(two_minor);
      inc_both_nxt  = $signed(two_minor - two_major);
      left_nxt      = (major != '0) ? major - CW'(1) : '0;
      color_nxt     = line_color;
    end else if (left_r == '0) begin
      // Advance with no line in progress: hold position, nothing drawn.
      emitted = 1'b0;
    end else begin
      dec_nxt = dec_pos ? dec_r + inc_both_r : dec_r + inc_minor_r;
      if (major_y_r) begin
        cur_y_nxt = cur_y_r + step_y;
        if (dec_pos) begin
          cur_x_nxt = cur_x_r + step_x;
        end
      end else begin
        cur_x_nxt = cur_x_r + step_x;
        if (dec_pos) begin
          cur_y_nxt = cur_y_r + step_y;
        end
      end
      left_nxt = left_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      dec_r       <= '0;
      inc_minor_r <= '0;
      inc_both_r  <= '0;
      left_r      <= '0;
      x_neg_r     <= 1'b0;
      y_neg_r     <= 1'b0;
      major_y_r   <= 1'b0;
      color_r     <= '0;
      pix_valid_r <= 1'b0;
    end else begin
      if (take) begin
        cur_x_r     <= cur_x_nxt;
        cur_y_r     <= cur_y_nxt;
        dec_r       <= dec_nxt;
        inc_minor_r <= inc_minor_nxt;
        inc_both_r  <= inc_both_nxt;
        left_r      <= left_nxt;
        x_neg_r     <= x_neg_nxt;
        y_neg_r     <= y_neg_nxt;
        major_y_r   <= major_y_nxt;
        color_r     <= color_nxt;
        pix_valid_r <= 1'b1;
      end else if (pix_ready) begin
        pix_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pix_flags_r.emitted <= emitted;
      pix_flags_r.active  <= (left_nxt != '0);
      pix_x_r             <= cur_x_nxt;
      pix_y_r             <= cur_y_nxt;
      pix_color_r         <= color_nxt;
    end
  end

  assign pix_valid = pix_valid_r;
  assign pix_flags = pix_flags_r;
  assign pix_x     = pix_x_r;
  assign pix_y     = pix_y_r;
  assign pix_color = pix_color_r;

endmodule

// ----- design/lbr_pixel_out.sv -----
// Output stage: screen clipping, linear index x + y * width, and the result register.
// Depends on lbr_pkg.
module lbr_pixel_out
  import lbr_pkg::*;
#(
  parameter int COORD_BITS = LBR_COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [LBR_REG_W-1:0]          screen_width,
  input  logic [LBR_REG_W-1:0]          screen_height,
  input  logic                          pix_valid,
  output logic                          pix_ready,
  input  lbr_flags_t                    pix_flags,
  input  logic signed [COORD_BITS-1:0]  pix_x,
  input  logic signed [COORD_BITS-1:0]  pix_y,
  input  logic [LBR_COLOR_W-1:0]        pix_color,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_pixel_valid,
  output logic                          out_line_active,
  output logic signed [COORD_BITS-1:0]  out_x,
  output logic signed [COORD_BITS-1:0]  out_y,
  output logic [LBR_IDX_W-1:0]          out_index,
  output logic [LBR_COLOR_W-1:0]        out_color
);

  localparam int CW   = COORD_BITS;
  localparam int CMPW = (CW - 1 > LBR_REG_W) ? CW - 1 : LBR_REG_W;
  localparam int PW   = CW - 1 + LBR_REG_W;
  localparam int SW   = ((PW > LBR_IDX_W) ? PW : LBR_IDX_W) + 1;

  logic [CMPW-1:0]          x_cmp, y_cmp, w_cmp, h_cmp;
  logic                     on_screen;
  logic [PW-1:0]            row_base;
  logic [SW-1:0]            index_sum;
  logic [LBR_IDX_W-1:0]     index_val;
  logic                     out_valid_r;
  logic                     pv_r, act_r;
  logic signed [CW-1:0]     x_r, y_r;
  logic [LBR_IDX_W-1:0]     index_r;
  logic [LBR_COLOR_W-1:0]   color_r;

  always_comb begin
    x_cmp     = CMPW'(pix_x[CW-2:0]);
    y_cmp     = CMPW'(pix_y[CW-2:0]);
    w_cmp     = CMPW'(screen_width);
    h_cmp     = CMPW'(screen_height);
    on_screen = pix_flags.emitted && !pix_x[CW-1] && !pix_y[CW-1] &&
                (x_cmp < w_cmp) && (y_cmp < h_cmp);
    row_base  = PW'(pix_y[CW-2:0]) * PW'(screen_width);
    index_sum = SW'(row_base) + SW'(pix_x[CW-2:0]);
    index_val = on_screen ? index_sum[LBR_IDX_W-1:0] : '0;
  end

  assign pix_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pix_ready) begin
      out_valid_r <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_valid && pix_ready) begin
      pv_r    <= on_screen;
      act_r   <= pix_flags.active;
      x_r     <= pix_x;
      y_r     <= pix_y;
      index_r <= index_val;
      color_r <= pix_color;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_valid = pv_r;
  assign out_line_active = act_r;
  assign out_x           = x_r;
  assign out_y           = y_r;
  assign out_index       = index_r;
  assign out_color       = color_r;

endmodule

// ----- design/lbr_checker.sv -----
// Port-level checker for the rasterizer, attached to the top level by bind.
// Depends on lbr_pkg and line_bresenham_rasterizer_macros.svh.
`include "line_bresenham_rasterizer_macros.svh"

module lbr_checker
  import lbr_pkg::*;
#(
  parameter int COORD_BITS = LBR_COORD_BITS
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [1:0]                   out_tuser,
  input logic [((2*COORD_BITS+LBR_IDX_W+LBR_COLOR_W+7)/8)*8-1:0] out_tdata
);

  localparam int CW = COORD_BITS;

  logic [LBR_IDX_W-1:0] chk_index;
  logic                 chk_x_neg, chk_y_neg;

  assign chk_index = out_tdata[2*CW+LBR_IDX_W-1:2*CW];
  assign chk_x_neg = out_tdata[CW-1];
  assign chk_y_neg = out_tdata[2*CW-1];

  // A stalled result keeps its payload.
  `LBR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser))

  // A clipped or idle pixel always reports index zero.
  `LBR_ASSERT_IMPL(a_clip_index, out_tvalid && !out_tuser[0], chk_index == '0)

  // A drawn pixel never has a negative coordinate.
  `LBR_ASSERT_IMPL(a_drawn_nonneg, out_tvalid && out_tuser[0], !chk_x_neg && !chk_y_neg)

  // With the result side empty the pipeline must be able to take an item.
  `LBR_ASSERT_IMPL(a_ready_when_empty, !out_tvalid, in_tready)

endmodule

bind line_bresenham_rasterizer lbr_checker #(.COORD_BITS(COORD_BITS)) u_lbr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);
